@@ rtl/socd_last_input_priority_defines.svh @@
// Assertion macros for the SOCD last-input-priority block.
// The macros expect clk and arst_n to be visible where they are used.
`ifndef SOCD_LAST_INPUT_PRIORITY_DEFINES_SVH
`define SOCD_LAST_INPUT_PRIORITY_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SOCD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("socd: assertion failed");
// Next-cycle implication, disabled during reset.
`define SOCD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("socd: assertion failed");
`else
`define SOCD_ASSERT_IMP(lbl, ante, cons)
`define SOCD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/socd_pkg.sv @@
// Shared constants, types and controller codes for the SOCD block.
`timescale 1ns / 1ps
package socd_pkg;

	localparam int PAIR_SLOTS = 8;
	localparam int CODE_W     = 32;
	localparam int IDX_W      = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_OUT0,
		S_OUT1
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // capture input item, restart scan
		logic scan_next;  // advance scan index
		logic claim;      // write pair into free slot at scan index
		logic update;     // update held flags, build results
		logic full;       // build pass-through result
		logic sel1;       // drive second result on output
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic hit;        // slot at scan index holds this pair
		logic free_slot;  // slot at scan index is unused
		logic at_end;     // scan index is the last slot
		logic two;        // current item produces two results
	} sts_t;

endpackage

@@ rtl/socd_if.sv @@
// Valid/ready channel interfaces for key events and emitted results.
`timescale 1ns / 1ps
interface socd_in_if;
	import socd_pkg::*;
	logic  valid;
	logic  ready;
	logic  command;
	code_t key_code;
	code_t opposing_code;

	modport source (output valid, command, key_code, opposing_code, input ready);
	modport sink   (input valid, command, key_code, opposing_code, output ready);
endinterface

interface socd_out_if;
	import socd_pkg::*;
	logic  valid;
	logic  ready;
	code_t out_code;
	logic  out_pressed;
	logic  table_full;
	logic  last;

	modport source (output valid, out_code, out_pressed, table_full, last, input ready);
	modport sink   (input valid, out_code, out_pressed, table_full, last, output ready);
endinterface

@@ rtl/socd_datapath.sv @@
// Pair table, scan index, held flags and result registers.
`timescale 1ns / 1ps
`include "socd_last_input_priority_defines.svh"
module socd_datapath import socd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output sts_t  sts,
	input  logic  command,
	input  code_t key_code,
	input  code_t opposing_code,
	output code_t out_code,
	output logic  out_pressed,
	output logic  table_full,
	output logic  last
);

	// Pair table
	code_t                 low_code_q  [PAIR_SLOTS];
	code_t                 high_code_q [PAIR_SLOTS];
	logic [PAIR_SLOTS-1:0] low_held_q;
	logic [PAIR_SLOTS-1:0] high_held_q;
	logic [PAIR_SLOTS-1:0] slot_valid_q;

	// Captured item
	logic  release_q;
	logic  is_low_q;
	code_t key_q;
	code_t opp_q;
	code_t lo_q;
	code_t hi_q;
	idx_t  idx_q;

	// Results
	code_t code0_q;
	code_t code1_q;
	logic  pressed0_q;
	logic  last0_q;
	logic  full_q;
	logic  two_q;

	logic  is_low;
	logic  other_held;

	assign is_low = key_code <= opposing_code;

	// Capture item, order the pair
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			release_q <= command;
			is_low_q  <= is_low;
			key_q     <= key_code;
			opp_q     <= opposing_code;
			lo_q      <= is_low ? key_code : opposing_code;
			hi_q      <= is_low ? opposing_code : key_code;
		end
	end

	// Scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.scan_next) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Slot status at scan index
	assign sts.hit       = slot_valid_q[idx_q] && (low_code_q[idx_q] == lo_q)
	                       && (high_code_q[idx_q] == hi_q);
	assign sts.free_slot = !slot_valid_q[idx_q];
	assign sts.at_end    = idx_q == IDX_W'(PAIR_SLOTS - 1);
	assign sts.two       = two_q;

	// Pair codes, written on claim
	always_ff @(posedge clk) begin
		if (cmd.claim) begin
			low_code_q[idx_q]  <= lo_q;
			high_code_q[idx_q] <= hi_q;
		end
	end

	// Opponent flag is the other key of the pair
	assign other_held = is_low_q ? high_held_q[idx_q] : low_held_q[idx_q];

	// Valid and held flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			low_held_q   <= '0;
			high_held_q  <= '0;
		end else if (cmd.claim) begin
			slot_valid_q[idx_q] <= 1'b1;
			low_held_q[idx_q]   <= 1'b0;
			high_held_q[idx_q]  <= 1'b0;
		end else if (cmd.update) begin
			if (is_low_q) begin
				low_held_q[idx_q] <= !release_q;
			end else begin
				high_held_q[idx_q] <= !release_q;
			end
		end
	end

	// Result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_q <= 1'b0;
		end else if (cmd.update) begin
			two_q <= other_held;
		end else if (cmd.full) begin
			two_q <= 1'b0;
		end
	end

	// Result payloads
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			full_q  <= 1'b0;
			last0_q <= !other_held;
			if (!release_q) begin
				code0_q    <= other_held ? opp_q : key_q;
				pressed0_q <= !other_held;
				code1_q    <= key_q;
			end else begin
				code0_q    <= key_q;
				pressed0_q <= 1'b0;
				code1_q    <= opp_q;
			end
		end else if (cmd.full) begin
			full_q     <= 1'b1;
			last0_q    <= 1'b1;
			code0_q    <= key_q;
			pressed0_q <= !release_q;
		end
	end

	// Output select: second result is always a final press
	assign out_code    = cmd.sel1 ? code1_q : code0_q;
	assign out_pressed = cmd.sel1 ? 1'b1 : pressed0_q;
	assign table_full  = cmd.sel1 ? 1'b0 : full_q;
	assign last        = cmd.sel1 ? 1'b1 : last0_q;

	// Checks
	`SOCD_ASSERT_NXT(a_claim_sets_valid, cmd.claim, slot_valid_q[idx_q])
	`SOCD_ASSERT_IMP(a_full_only_when_all_used, cmd.full, &slot_valid_q)
	`SOCD_ASSERT_IMP(a_claim_on_free_only, cmd.claim, !slot_valid_q[idx_q])

endmodule

@@ rtl/socd_ctrl.sv @@
// Controller: scan sequencing, result emission and handshakes.
`timescale 1ns / 1ps
`include "socd_last_input_priority_defines.svh"
module socd_ctrl import socd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (sts.hit) begin
					state_d = S_UPDATE;
				end else if (sts.free_slot) begin
					cmd.claim = 1'b1;
					state_d   = S_UPDATE;
				end else if (sts.at_end) begin
					cmd.full = 1'b1;
					state_d  = S_OUT0;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_OUT0;
			end
			S_OUT0: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = sts.two ? S_OUT1 : S_IDLE;
				end
			end
			S_OUT1: begin
				out_valid = 1'b1;
				cmd.sel1  = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Checks
	`SOCD_ASSERT_IMP(a_no_accept_while_emitting, in_ready, !out_valid)
	`SOCD_ASSERT_IMP(a_second_only_when_two, state_q == S_OUT1, sts.two)
	`SOCD_ASSERT_NXT(a_hit_goes_update, state_q == S_SCAN && sts.hit, state_q == S_UPDATE)

endmodule

@@ rtl/socd_last_input_priority.sv @@
// Top level of the SOCD last-input-priority resolver.
//
// Key events enter on the events channel (command, key_code,
// opposing_code); emitted key state changes leave on the results
// channel (out_code, out_pressed, table_full, last). A transfer happens
// when valid and ready are both high at a rising clock edge.
// Each event gives one or two results; last marks the final one.
// One event is handled at a time: events.ready is high only while idle.
// After an event transfer the slot scan checks one slot a cycle; a hit or
// a free slot leads on to one update step, a full table straight to the
// first result. Each result is held on the channel until it is taken.
// If the results receiver stalls, the current result holds and no new
// event is taken until all results of the current event have moved.
// Reset (arst_n low) clears the slot valid marks and held flags at once;
// no clearing pass is needed and the block is ready right after reset.
`timescale 1ns / 1ps
module socd_last_input_priority import socd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	socd_in_if.sink    events,
	socd_out_if.source results
);

	cmd_t cmd;
	sts_t sts;

	socd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (events.valid),
		.in_ready  (events.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	socd_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.command       (events.command),
		.key_code      (events.key_code),
		.opposing_code (events.opposing_code),
		.out_code      (results.out_code),
		.out_pressed   (results.out_pressed),
		.table_full    (results.table_full),
		.last          (results.last)
	);

endmodule

@@ tb/socd_last_input_priority_checker.sv @@
// Checker for the SOCD resolver: tracks the pair table and compares every result transfer.
`timescale 1ns / 1ps
module socd_last_input_priority_checker import socd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  ev_valid,
	input  logic  ev_ready,
	input  logic  ev_command,
	input  code_t ev_key_code,
	input  code_t ev_opposing_code,
	input  logic  res_valid,
	input  logic  res_ready,
	input  code_t res_out_code,
	input  logic  res_out_pressed,
	input  logic  res_table_full,
	input  logic  res_last,
	output int    mismatches,
	output int    outstanding,
	output int    checked,
	output int    doubles,
	output int    passthroughs
);

	localparam int MAX_PRINTS = 40;

	// One emitted key state change
	typedef struct packed {
		code_t code;
		logic  pressed;
		logic  full;
		logic  last;
	} key_change_t;

	key_change_t due_q[$];
	key_change_t head;
	int          printed;

	// Shadow copy of the pair table
	code_t slot_lo[PAIR_SLOTS];
	code_t slot_hi[PAIR_SLOTS];
	logic  lo_down[PAIR_SLOTS];
	logic  hi_down[PAIR_SLOTS];
	logic  slot_used[PAIR_SLOTS];

	task automatic report(string what, logic [31:0] want, logic [31:0] got);
		if (printed < MAX_PRINTS) begin
			$display("mismatch at %0t ns: %s expected %h got %h", $time, what, want, got);
			printed++;
		end
		mismatches++;
	endtask

	// Find or claim the slot of the pair, then queue the key changes it causes
	task automatic resolve_event(logic release_cmd, code_t key, code_t opp);
		logic  is_low;
		logic  opp_down;
		code_t lo;
		code_t hi;
		int    slot;
		int    i;
		is_low = (key <= opp);
		lo     = is_low ? key : opp;
		hi     = is_low ? opp : key;
		slot   = -1;
		for (i = 0; i < PAIR_SLOTS && slot < 0; i++) begin
			if (slot_used[i]) begin
				if (slot_lo[i] == lo && slot_hi[i] == hi)
					slot = i;
			end else begin
				slot_lo[i]   = lo;
				slot_hi[i]   = hi;
				lo_down[i]   = 1'b0;
				hi_down[i]   = 1'b0;
				slot_used[i] = 1'b1;
				slot         = i;
			end
		end

		if (slot < 0) begin
			// no room: pass through unchanged
			due_q.push_back('{key, !release_cmd, 1'b1, 1'b1});
			passthroughs++;
		end else if (!release_cmd) begin
			opp_down = is_low ? hi_down[slot] : lo_down[slot];
			if (is_low)
				lo_down[slot] = 1'b1;
			else
				hi_down[slot] = 1'b1;
			if (opp_down) begin
				due_q.push_back('{opp, 1'b0, 1'b0, 1'b0});
				doubles++;
			end
			due_q.push_back('{key, 1'b1, 1'b0, 1'b1});
		end else begin
			if (is_low)
				lo_down[slot] = 1'b0;
			else
				hi_down[slot] = 1'b0;
			opp_down = is_low ? hi_down[slot] : lo_down[slot];
			due_q.push_back('{key, 1'b0, 1'b0, !opp_down});
			if (opp_down) begin
				due_q.push_back('{opp, 1'b1, 1'b0, 1'b1});
				doubles++;
			end
		end
	endtask

	// Compare result transfers first, then predict from event transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PAIR_SLOTS; k++) begin
				slot_used[k] = 1'b0;
				lo_down[k]   = 1'b0;
				hi_down[k]   = 1'b0;
			end
			due_q.delete();
			mismatches   = 0;
			outstanding  = 0;
			checked      = 0;
			doubles      = 0;
			passthroughs = 0;
			printed      = 0;
		end else begin
			if (res_valid && res_ready) begin
				checked++;
				if (due_q.size() == 0) begin
					report("unexpected result, out_code", '0, res_out_code);
				end else begin
					head = due_q.pop_front();
					if (res_out_code !== head.code)
						report("out_code", head.code, res_out_code);
					if (res_out_pressed !== head.pressed)
						report("out_pressed", 32'(head.pressed), 32'(res_out_pressed));
					if (res_table_full !== head.full)
						report("table_full", 32'(head.full), 32'(res_table_full));
					if (res_last !== head.last)
						report("last", 32'(head.last), 32'(res_last));
				end
			end
			if (ev_valid && ev_ready)
				resolve_event(ev_command, ev_key_code, ev_opposing_code);
			outstanding = due_q.size();
		end
	end

endmodule

@@ tb/socd_last_input_priority_tb.sv @@
// Testbench top for the SOCD resolver: clock, reset, key event stimulus and verdict.
`timescale 1ns / 1ps
module socd_last_input_priority_tb;
	import socd_pkg::*;

	localparam logic KEY_PRESS      = 1'b0;
	localparam logic KEY_RELEASE    = 1'b1;
	localparam int   RANDOM_ITEMS   = 1400;
	localparam int   POOL_PAIRS     = 10;
	localparam int   HOLD_CYCLES    = 400;
	localparam int   HOLD_AFTER     = 300;
	localparam int   WATCHDOG_LIMIT = 3000;
	localparam int   TAIL_CYCLES    = PAIR_SLOTS + 8;

	logic clk;
	logic arst_n;

	socd_in_if  ev_if ();
	socd_out_if res_if ();

	int   sent;
	logic quiet;
	int   idle_cycles;
	int   mismatches;
	int   outstanding;
	int   checked;
	int   doubles;
	int   passthroughs;

	// Key pairs: the first eight fill the table, the last two never fit
	code_t pool_a[POOL_PAIRS];
	code_t pool_b[POOL_PAIRS];

	socd_last_input_priority uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (ev_if),
		.results (res_if)
	);

	socd_last_input_priority_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.ev_valid         (ev_if.valid),
		.ev_ready         (ev_if.ready),
		.ev_command       (ev_if.command),
		.ev_key_code      (ev_if.key_code),
		.ev_opposing_code (ev_if.opposing_code),
		.res_valid        (res_if.valid),
		.res_ready        (res_if.ready),
		.res_out_code     (res_if.out_code),
		.res_out_pressed  (res_if.out_pressed),
		.res_table_full   (res_if.table_full),
		.res_last         (res_if.last),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.checked          (checked),
		.doubles          (doubles),
		.passthroughs     (passthroughs)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one key event after a gap and wait for its transfer
	task automatic send_event(logic cmd, code_t key, code_t opp);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			ev_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		ev_if.valid         <= 1'b1;
		ev_if.command       <= cmd;
		ev_if.key_code      <= key;
		ev_if.opposing_code <= opp;
		do
			@(posedge clk);
		while (!ev_if.ready);
		sent++;
	endtask

	// Result receiver: random stalls, one long hold-off to back up the input
	initial begin
		int   stall_left;
		logic held_off;
		res_if.ready = 1'b0;
		stall_left   = 0;
		held_off     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && sent >= HOLD_AFTER) begin
				held_off   = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 99) < 25) begin
				res_if.ready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", idle_cycles);
				$display("FAIL socd_last_input_priority");
				$finish;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int    n;
		int    p;
		int    r;
		logic  cmd;
		code_t key;
		code_t opp;
		arst_n              = 1'b0;
		sent                = 0;
		quiet               = 1'b0;
		ev_if.valid         = 1'b0;
		ev_if.command       = KEY_PRESS;
		ev_if.key_code      = '0;
		ev_if.opposing_code = '0;

		pool_a[0] = '0;
		pool_b[0] = '1;
		pool_a[1] = $urandom;
		pool_b[1] = pool_a[1];
		for (n = 2; n < POOL_PAIRS; n++) begin
			pool_a[n] = $urandom;
			pool_b[n] = $urandom;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Extreme codes: opponent interplay on both sides, duplicates
		send_event(KEY_PRESS,   pool_a[0], pool_b[0]);
		send_event(KEY_PRESS,   pool_b[0], pool_a[0]);
		send_event(KEY_RELEASE, pool_b[0], pool_a[0]);
		send_event(KEY_RELEASE, pool_a[0], pool_b[0]);
		send_event(KEY_PRESS,   pool_b[0], pool_a[0]);
		send_event(KEY_PRESS,   pool_a[0], pool_b[0]);
		send_event(KEY_RELEASE, pool_a[0], pool_b[0]);
		send_event(KEY_PRESS,   pool_b[0], pool_a[0]);
		send_event(KEY_RELEASE, pool_b[0], pool_a[0]);
		send_event(KEY_RELEASE, pool_b[0], pool_a[0]);
		// key that opposes itself
		send_event(KEY_PRESS,   pool_a[1], pool_b[1]);
		send_event(KEY_RELEASE, pool_a[1], pool_b[1]);
		// fill the rest of the table
		for (n = 2; n < PAIR_SLOTS; n++)
			send_event(KEY_PRESS, pool_a[n], pool_b[n]);
		// table full: pass-through both ways
		send_event(KEY_PRESS,   pool_a[PAIR_SLOTS], pool_b[PAIR_SLOTS]);
		send_event(KEY_RELEASE, pool_a[PAIR_SLOTS], pool_b[PAIR_SLOTS]);
		send_event(KEY_PRESS,   pool_b[2], pool_a[2]);

		// Random part: mostly known pairs, some unknown pairs and raw codes
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 600 && n < 800);
			r     = $urandom_range(0, 99);
			cmd   = 1'($urandom_range(0, 1));
			if (r < 82)
				p = $urandom_range(0, PAIR_SLOTS - 1);
			else if (r < 92)
				p = $urandom_range(PAIR_SLOTS, POOL_PAIRS - 1);
			else
				p = -1;
			if (p >= 0) begin
				if ($urandom_range(0, 1)) begin
					key = pool_b[p];
					opp = pool_a[p];
				end else begin
					key = pool_a[p];
					opp = pool_b[p];
				end
			end else begin
				key = $urandom;
				opp = ($urandom_range(0, 3) == 0) ? key : code_t'($urandom);
			end
			send_event(cmd, key, opp);
		end
		quiet = 1'b0;
		@(negedge clk);
		ev_if.valid <= 1'b0;

		wait (outstanding == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d key events and %0d results: %0d with an opponent change,",
			sent, checked, doubles);
		$display("%0d table-full pass-throughs, one long receiver hold-off", passthroughs);
		if (mismatches == 0)
			$display("PASS socd_last_input_priority");
		else
			$display("FAIL socd_last_input_priority");
		$finish;
	end

endmodule
